// File: sv/wat_pkg.sv
// ----------------------------------------------------------------------------
// wat_pkg
// Shared types, codes and tables of the wakeup appointment table.
// ----------------------------------------------------------------------------
package wat_pkg;

  // Request commands
  localparam logic [1:0] OP_SET     = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_LIST    = 2'd2;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  // Response status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Response operation type
  localparam logic [2:0] OPT_SET_REL = 3'd0;
  localparam logic [2:0] OPT_SET_ABS = 3'd1;
  localparam logic [2:0] OPT_CLR_REL = 3'd2;
  localparam logic [2:0] OPT_CLR_ABS = 3'd3;
  localparam logic [2:0] OPT_NONE    = 3'd4;

  // Register indexes (APB word address)
  localparam logic [1:0] REG_OWN_PART = 2'd0;
  localparam logic [1:0] REG_MIN_YEAR = 2'd1;
  localparam logic [1:0] REG_MAX_YEAR = 2'd2;

  // Maximum number of items one list request answers with
  localparam int unsigned OUT_CAP   = 16;
  localparam int unsigned OUT_CAP_W = $clog2(OUT_CAP);

  // Divisibility by 25 over 16 bits: y * inverse(25) mod 2^16 <= 65535 / 25
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_LIM = 16'd2621;

  typedef struct packed {
    logic [7:0]  own_partition;
    logic [15:0] min_year;
    logic [15:0] max_year;
  } cfg_t;

  typedef struct packed {
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } date_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  partition;
    logic [7:0]  clock_type;
    logic [31:0] app_id;
    logic [31:0] relative_seconds;
    date_t       date;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  op_type;
    logic        list_empty;
    logic        entry_clock;
    logic [31:0] entry_app_id;
    logic [55:0] when;
    logic        last;
  } res_t;

  // One memory word: key id and packed appointment time
  typedef struct packed {
    logic [31:0] app_id;
    logic [55:0] when;
  } slot_t;

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    unique case (month)
      4'd2:                      days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
      default:                   days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

// File: sv/wat_mem.sv
// ----------------------------------------------------------------------------
// wat_mem
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wat_mem #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned AW      = 4
) (
  input  logic            clk_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  wat_pkg::slot_t  wdata_i,
  output wat_pkg::slot_t  rdata_o
);
  import wat_pkg::*;

  slot_t mem_q [ENTRIES];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/wat_date_chk.sv
// ----------------------------------------------------------------------------
// wat_date_chk
// Absolute date check: year bounds, Gregorian month length, time of day.
// ----------------------------------------------------------------------------
module wat_date_chk (
  input  wat_pkg::date_t date_i,
  input  wat_pkg::cfg_t  cfg_i,
  output logic           ok_o
);
  import wat_pkg::*;

  logic [15:0] prod;
  logic        div25;
  logic        leap;
  logic [4:0]  lim;

  // Year is a multiple of 25 exactly when its product with the inverse of 25
  // stays in the low slice of the 16-bit range.
  assign prod  = date_i.year * INV25;
  assign div25 = (prod <= DIV25_LIM);
  assign leap  = ((date_i.year[1:0] == 2'd0) && !div25) ||
                 ((date_i.year[3:0] == 4'd0) && div25);
  assign lim   = month_days(date_i.month[3:0], leap);

  assign ok_o = (date_i.year >= cfg_i.min_year) && (date_i.year <= cfg_i.max_year) &&
                (date_i.month >= 8'd1) && (date_i.month <= 8'd12) &&
                (date_i.day >= 8'd1) && (date_i.day <= {3'b000, lim}) &&
                (date_i.hour <= 8'd23) && (date_i.minute <= 8'd59) &&
                (date_i.second <= 8'd59);

endmodule

// File: sv/wat_seq.sv
// ----------------------------------------------------------------------------
// wat_seq
// Request sequencer: scans the slot memory, updates valid and clock flags,
// writes slots back and drives the result register.
// ----------------------------------------------------------------------------
module wat_seq #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned AW      = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wat_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  wat_pkg::req_t   in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output wat_pkg::res_t   out_res_o,
  output wat_pkg::date_t  date_o,
  input  logic            date_ok_i,
  output logic            mem_re_o,
  output logic [AW-1:0]   mem_raddr_o,
  output logic            mem_we_o,
  output logic [AW-1:0]   mem_waddr_o,
  output wat_pkg::slot_t  mem_wdata_o,
  input  wat_pkg::slot_t  mem_rdata_i
);
  import wat_pkg::*;

  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_FETCH  = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  req_t                 req_q, req_d;
  logic [ENTRIES-1:0]   valid_q, valid_d;
  logic [ENTRIES-1:0]   clock_q, clock_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [AW-1:0]        rd_idx_q, rd_idx_d;
  logic                 hit_q, hit_d;
  logic [AW-1:0]        hit_idx_q, hit_idx_d;
  logic                 free_q, free_d;
  logic [AW-1:0]        free_idx_q, free_idx_d;
  logic [OUT_CAP_W-1:0] emit_q, emit_d;
  logic                 out_vld_q, out_vld_d;
  res_t                 out_q, out_d;

  logic [AW-1:0]        idx;
  logic                 scan_end;
  logic                 clk_bit;
  logic                 clk_ok;
  logic                 req_ok;
  logic [2:0]           opt;
  logic                 out_free;
  logic [ENTRIES-1:0]   match_vec;
  logic                 later_match;
  logic                 key_hit;
  logic                 item_last;
  logic [AW-1:0]        slot_idx;
  logic [55:0]          when_new;

  function automatic res_t mk_resp(input logic [1:0] st, input logic [2:0] op_type,
                                   input logic [31:0] id);
    res_t r;
    r.status       = st;
    r.op_type      = op_type;
    r.list_empty   = 1'b0;
    r.entry_clock  = 1'b0;
    r.entry_app_id = (st != ST_OK) ? id : 32'd0;
    r.when         = 56'd0;
    r.last         = 1'b1;
    return r;
  endfunction

  assign idx      = cnt_q[AW-1:0];
  assign scan_end = (cnt_q == CW'(ENTRIES));
  assign clk_bit  = req_q.clock_type[0];
  assign clk_ok   = (req_q.clock_type[7:1] == 7'd0);
  assign req_ok   = (req_q.partition == cfg_i.own_partition) && clk_ok;
  assign out_free = !out_vld_q || out_ready_i;
  assign slot_idx = hit_q ? hit_idx_q : free_idx_q;
  assign when_new = clk_bit ? req_q.date : {req_q.relative_seconds, 24'd0};
  assign key_hit  = rd_vld_q && valid_q[rd_idx_q] && (clock_q[rd_idx_q] == clk_bit) &&
                    (mem_rdata_i.app_id == req_q.app_id);
  assign item_last = (emit_q == OUT_CAP_W'(OUT_CAP - 1)) || !later_match;

  always_comb begin
    opt = OPT_NONE;
    if (clk_ok) begin
      if (req_q.op == OP_SET) begin
        opt = clk_bit ? OPT_SET_ABS : OPT_SET_REL;
      end else if (req_q.op == OP_CLEAR) begin
        opt = clk_bit ? OPT_CLR_ABS : OPT_CLR_REL;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      match_vec[j] = valid_q[j] && (clock_q[j] == clk_bit);
    end
  end

  // Any listed entry left above the current slot
  always_comb begin
    later_match = 1'b0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (match_vec[j] && (AW'(j) > idx)) begin
        later_match = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    valid_d     = valid_q;
    clock_d     = clock_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    emit_d      = emit_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_d       = out_q;
    mem_re_o    = 1'b0;
    mem_we_o    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        cnt_d  = '0;
        hit_d  = 1'b0;
        free_d = 1'b0;
        emit_d = '0;
        if (req_q.op == OP_LIST) begin
          if (req_ok) begin
            state_d = S_FETCH;
          end else if (out_free) begin
            out_vld_d = 1'b1;
            out_d     = mk_resp(ST_INVALID, OPT_NONE, 32'd0);
            out_d.entry_app_id = 32'd0;
            state_d   = S_IDLE;
          end
        end else if (req_ok && ((req_q.op == OP_CLEAR) ||
                     ((req_q.op == OP_SET) && (!clk_bit || date_ok_i)))) begin
          state_d = S_SCAN;
        end else if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = mk_resp(ST_INVALID, opt, req_q.app_id);
          state_d   = S_IDLE;
        end
      end

      S_SCAN: begin
        if (!scan_end) begin
          mem_re_o = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = idx;
          cnt_d    = cnt_q + CW'(1);
          if (!valid_q[idx] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = idx;
          end
        end
        if (key_hit && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = rd_idx_q;
        end
        if (scan_end && !rd_vld_q) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
          if (req_q.op == OP_CLEAR) begin
            if (hit_q) begin
              valid_d[hit_idx_q] = 1'b0;
              out_d = mk_resp(ST_OK, opt, req_q.app_id);
            end else begin
              out_d = mk_resp(ST_MISS, opt, req_q.app_id);
            end
          end else if (hit_q || free_q) begin
            mem_we_o          = 1'b1;
            valid_d[slot_idx] = 1'b1;
            clock_d[slot_idx] = clk_bit;
            out_d = mk_resp(ST_OK, opt, req_q.app_id);
          end else begin
            out_d = mk_resp(ST_MISS, opt, req_q.app_id);
          end
        end
      end

      S_FETCH: begin
        if (scan_end) begin
          // No entry of this clock type: one empty item
          if (out_free) begin
            out_vld_d         = 1'b1;
            out_d             = mk_resp(ST_OK, OPT_NONE, 32'd0);
            out_d.list_empty  = 1'b1;
            out_d.entry_clock = clk_bit;
            state_d           = S_IDLE;
          end
        end else if (match_vec[idx]) begin
          mem_re_o = 1'b1;
          state_d  = S_EMIT;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end

      S_EMIT: begin
        // Read data stays in the memory output register until the next read
        if (out_free) begin
          out_vld_d          = 1'b1;
          out_d.status       = ST_OK;
          out_d.op_type      = OPT_NONE;
          out_d.list_empty   = 1'b0;
          out_d.entry_clock  = clk_bit;
          out_d.entry_app_id = mem_rdata_i.app_id;
          out_d.when         = mem_rdata_i.when;
          out_d.last         = item_last;
          emit_d             = emit_q + OUT_CAP_W'(1);
          cnt_d              = cnt_q + CW'(1);
          state_d            = item_last ? S_IDLE : S_FETCH;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      clock_q   <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      emit_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      clock_q   <= clock_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      emit_q    <= emit_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    rd_idx_q   <= rd_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    out_q      <= out_d;
  end

  assign in_ready_o         = (state_q == S_IDLE);
  assign out_valid_o        = out_vld_q;
  assign out_res_o          = out_q;
  assign date_o             = req_q.date;
  assign mem_raddr_o        = idx;
  assign mem_waddr_o        = slot_idx;
  assign mem_wdata_o.app_id = req_q.app_id;
  assign mem_wdata_o.when   = when_new;

endmodule

// File: sv/wakeup_appointment_table_top.sv
// ----------------------------------------------------------------------------
// wakeup_appointment_table_top
// Wakeup appointment table with APB register port and stream request and
// result channels.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         request: tuser = op, tdata = partition .. second
// m_axis    out        result: tuser = status/op_type/list_empty, tdata = entry
// apb       in/out     own_partition, min_year, max_year
//
// Set and clear run from one request transfer to the next through accept,
// check, one memory read per slot, a compare and a settle step after the
// last read, then the write back. A list walks the slots in order and reads
// and emits each listed entry before the next request is taken.
// Reset empties the table at once through the per-slot valid flags.
// A stalled result holds in the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module wakeup_appointment_table_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // Requests
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // partition[7:0], clock_type[15:8], app_id[47:16], relative_seconds[79:48],
  // year[95:80], month[103:96], day[111:104], hour[119:112], minute[127:120],
  // second[135:128]
  input  logic [135:0] s_axis_tdata_i,
  // op[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  // Results
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // entry_clock[0], entry_app_id[32:1], when[88:33], zero[95:89]
  output logic [95:0]  m_axis_tdata_o,
  // status[1:0], op_type[4:2], list_empty[5]
  output logic [5:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);
  import wat_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [7:0]  own_partition_q;
  logic [15:0] min_year_q;
  logic [15:0] max_year_q;
  cfg_t        cfg;
  req_t        req;
  res_t        res;
  date_t       date;
  logic        date_ok;
  logic        mem_re;
  logic        mem_we;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  slot_t       mem_wdata;
  slot_t       mem_rdata;
  logic        cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_partition_q <= 8'd1;
      min_year_q      <= 16'd1970;
      max_year_q      <= 16'd2105;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_OWN_PART: own_partition_q <= pwdata[7:0];
        REG_MIN_YEAR: min_year_q      <= pwdata[15:0];
        REG_MAX_YEAR: max_year_q      <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_OWN_PART: prdata = {24'd0, own_partition_q};
      REG_MIN_YEAR: prdata = {16'd0, min_year_q};
      REG_MAX_YEAR: prdata = {16'd0, max_year_q};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg.own_partition = own_partition_q;
  assign cfg.min_year      = min_year_q;
  assign cfg.max_year      = max_year_q;

  // Unpack request
  assign req.op               = s_axis_tuser_i;
  assign req.partition        = s_axis_tdata_i[7:0];
  assign req.clock_type       = s_axis_tdata_i[15:8];
  assign req.app_id           = s_axis_tdata_i[47:16];
  assign req.relative_seconds = s_axis_tdata_i[79:48];
  assign req.date.year        = s_axis_tdata_i[95:80];
  assign req.date.month       = s_axis_tdata_i[103:96];
  assign req.date.day         = s_axis_tdata_i[111:104];
  assign req.date.hour        = s_axis_tdata_i[119:112];
  assign req.date.minute      = s_axis_tdata_i[127:120];
  assign req.date.second      = s_axis_tdata_i[135:128];

  wat_seq #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_req_i    (req),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res),
    .date_o      (date),
    .date_ok_i   (date_ok),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  wat_date_chk u_date_chk (
    .date_i (date),
    .cfg_i  (cfg),
    .ok_o   (date_ok)
  );

  wat_mem #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Pack result
  assign m_axis_tdata_o = {7'd0, res.when, res.entry_app_id, res.entry_clock};
  assign m_axis_tuser_o = {res.list_empty, res.op_type, res.status};
  assign m_axis_tlast_o = res.last;

`ifndef NO_ASSERTIONS
  // A request transfer starts work: no second request in the next cycle
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request accepted while previous one in progress");

  // Write back never overlaps a scan read
  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("slot memory read and write in the same cycle");

  // A list still running blocks new requests
  a_list_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> !s_axis_tready_o)
    else $error("request accepted during a list");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wakeup appointment table. Requests go in on the
// stream input with random gaps and the results are compared, field by field
// and in order, against a predicted copy of the appointment table. APB writes
// move the partition and year window through several settings between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import wat_pkg::*;

  localparam int unsigned SLOTS     = 16;
  localparam longint      LIMIT_NS  = 64'd10_000_000;
  localparam int unsigned DRAIN     = 60;
  localparam int unsigned HOLD_OFF  = 300;

  logic         clk_i;
  logic         rst_ni;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [135:0] s_axis_tdata_i;
  logic [1:0]   s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [95:0]  m_axis_tdata_o;
  logic [5:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;

  bit          idling;
  int unsigned sink_hold;

  // Predicted appointment table and the queue of answers it still owes
  class appointment_board;
    logic [7:0]  own_part = 8'd1;
    logic [15:0] year_lo  = 16'd1970;
    logic [15:0] year_hi  = 16'd2105;
    bit          slot_used [SLOTS];
    bit          slot_abs  [SLOTS];
    logic [31:0] slot_id   [SLOTS];
    logic [55:0] slot_time [SLOTS];
    res_t        pending [$];
    int unsigned errors, requests, results, listed, empty_lists;
    int unsigned full_refusals, clear_misses;

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_OWN_PART: own_part = value[7:0];
        REG_MIN_YEAR: year_lo  = value[15:0];
        REG_MAX_YEAR: year_hi  = value[15:0];
        default: ;
      endcase
    endfunction

    function bit date_valid(date_t dt);
      int unsigned y, month_len;
      bit leap;
      y = dt.year;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      if (dt.year < year_lo || dt.year > year_hi) return 1'b0;
      if (dt.month < 1 || dt.month > 12) return 1'b0;
      case (dt.month)
        8'd2:                     month_len = leap ? 29 : 28;
        8'd4, 8'd6, 8'd9, 8'd11:  month_len = 30;
        default:                  month_len = 31;
      endcase
      if (dt.day < 1 || dt.day > month_len) return 1'b0;
      return (dt.hour < 24) && (dt.minute < 60) && (dt.second < 60);
    endfunction

    function int find_key(logic [31:0] id, logic abs);
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && slot_id[i] == id && slot_abs[i] == abs) return i;
      return -1;
    endfunction

    function res_t make_answer(logic [1:0] st, logic [2:0] ot, logic empty, logic clk,
                               logic [31:0] id, logic [55:0] tm, logic fin);
      res_t a;
      a.status       = st;
      a.op_type      = ot;
      a.list_empty   = empty;
      a.entry_clock  = clk;
      a.entry_app_id = id;
      a.when         = tm;
      a.last         = fin;
      return a;
    endfunction

    function void note_request(req_t r);
      bit          clk_ok, req_ok, time_ok;
      logic        abs;
      logic [1:0]  st;
      logic [2:0]  ot;
      logic [55:0] tm;
      int          hit, n_match, k;
      clk_ok = (r.clock_type <= 8'd1);
      req_ok = clk_ok && (r.partition == own_part);
      abs = r.clock_type[0];
      requests++;
      if (r.op == OP_LIST) begin
        if (!req_ok) begin
          pending.push_back(make_answer(ST_INVALID, OPT_NONE, 1'b0, 1'b0, '0, '0, 1'b1));
          return;
        end
        n_match = 0;
        for (int i = 0; i < SLOTS; i++)
          if (slot_used[i] && slot_abs[i] == abs) n_match++;
        if (n_match == 0) begin
          empty_lists++;
          pending.push_back(make_answer(ST_OK, OPT_NONE, 1'b1, abs, '0, '0, 1'b1));
          return;
        end
        k = 0;
        for (int i = 0; i < SLOTS; i++)
          if (slot_used[i] && slot_abs[i] == abs) begin
            k++;
            listed++;
            pending.push_back(make_answer(ST_OK, OPT_NONE, 1'b0, slot_abs[i], slot_id[i],
                                          slot_time[i], k == n_match));
          end
        return;
      end
      st = ST_INVALID;
      ot = OPT_NONE;
      if (clk_ok && r.op == OP_SET)   ot = abs ? OPT_SET_ABS : OPT_SET_REL;
      if (clk_ok && r.op == OP_CLEAR) ot = abs ? OPT_CLR_ABS : OPT_CLR_REL;
      if (req_ok) begin
        hit = find_key(r.app_id, abs);
        if (r.op == OP_CLEAR) begin
          if (hit < 0) begin
            st = ST_MISS;
            clear_misses++;
          end else begin
            slot_used[hit] = 1'b0;
            st = ST_OK;
          end
        end else if (r.op == OP_SET) begin
          // The date is checked before any slot is picked
          time_ok = abs ? date_valid(r.date) : 1'b1;
          tm = abs ? 56'(r.date) : {r.relative_seconds, 24'h0};
          if (time_ok) begin
            if (hit < 0) begin
              for (int i = SLOTS - 1; i >= 0; i--)
                if (!slot_used[i]) hit = i;
            end
            if (hit < 0) begin
              st = ST_MISS;
              full_refusals++;
            end else begin
              slot_used[hit] = 1'b1;
              slot_abs[hit]  = abs;
              slot_id[hit]   = r.app_id;
              slot_time[hit] = tm;
              st = ST_OK;
            end
          end
        end
      end
      pending.push_back(make_answer(st, ot, 1'b0, 1'b0, (st != ST_OK) ? r.app_id : '0,
                                    '0, 1'b1));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $error("result transfer with no answer outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      results++;
      compare_field("status",       64'(want.status),       64'(got.status));
      compare_field("op_type",      64'(want.op_type),      64'(got.op_type));
      compare_field("list_empty",   64'(want.list_empty),   64'(got.list_empty));
      compare_field("entry_clock",  64'(want.entry_clock),  64'(got.entry_clock));
      compare_field("entry_app_id", 64'(want.entry_app_id), 64'(got.entry_app_id));
      compare_field("when",         64'(want.when),         64'(got.when));
      compare_field("last",         64'(want.last),         64'(got.last));
    endfunction
  endclass

  appointment_board board = new;

  wakeup_appointment_table_top #(
    .ENTRIES(SLOTS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Mostly back to back, now and then a short gap, rarely a long one
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idling || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic date_t calendar(logic [15:0] y, logic [7:0] mo, logic [7:0] d,
                                     logic [7:0] h, logic [7:0] mi, logic [7:0] s);
    date_t dt;
    dt.year   = y;
    dt.month  = mo;
    dt.day    = d;
    dt.hour   = h;
    dt.minute = mi;
    dt.second = s;
    return dt;
  endfunction

  function automatic req_t build_request(logic [1:0] op, logic [7:0] part, logic [7:0] clk,
                                         logic [31:0] id, logic [31:0] secs, date_t dt);
    req_t r;
    r.op               = op;
    r.partition        = part;
    r.clock_type       = clk;
    r.app_id           = id;
    r.relative_seconds = secs;
    r.date             = dt;
    return r;
  endfunction

  // Mostly well-formed requests on a small key pool so that sets, clears and
  // lists keep meeting each other; the rest is raw noise in every field
  function automatic req_t random_request(int unsigned set_w, int unsigned clr_w);
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < set_w)              r.op = OP_SET;
    else if (pick < set_w + clr_w) r.op = OP_CLEAR;
    else if (pick < 96)            r.op = OP_LIST;
    else                           r.op = OP_UNKNOWN;
    r.partition  = ($urandom_range(0, 9) != 0) ? board.own_part : 8'($urandom);
    r.clock_type = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 1)) : 8'($urandom);
    r.app_id     = ($urandom_range(0, 3) != 0) ? (32'hC0DE_0000 | $urandom_range(0, 11))
                                               : $urandom;
    r.relative_seconds = $urandom;
    if ($urandom_range(0, 4) != 0) begin
      r.date.year   = 16'($urandom_range(board.year_lo, board.year_hi));
      r.date.month  = 8'($urandom_range(1, 12));
      r.date.day    = 8'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 31 : 28));
      r.date.hour   = 8'($urandom_range(0, 23));
      r.date.minute = 8'($urandom_range(0, 59));
      r.date.second = 8'($urandom_range(0, 59));
    end else begin
      r.date = date_t'(56'({$urandom, $urandom}));
    end
    return r;
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_reg(idx, value);
  endtask

  task automatic configure(input logic [7:0] part, input logic [15:0] lo,
                           input logic [15:0] hi);
    apb_write(REG_OWN_PART, {24'h0, part});
    apb_write(REG_MIN_YEAR, {16'h0, lo});
    apb_write(REG_MAX_YEAR, {16'h0, hi});
  endtask

  // Valid stays high across back-to-back transfers; drop it only for a gap
  task automatic send_request(input req_t r);
    int unsigned gap;
    gap = gap_length();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= r.op;
    s_axis_tdata_i  <= {r.date.second, r.date.minute, r.date.hour, r.date.day,
                        r.date.month, r.date.year, r.relative_seconds, r.app_id,
                        r.clock_type, r.partition};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_request(r);
  endtask

  task automatic drain_answers();
    s_axis_tvalid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned set_w,
                              input int unsigned clr_w);
    repeat (count) send_request(random_request(set_w, clr_w));
    drain_answers();
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold != 0) begin
        stall_left = sink_hold;
        sink_hold = 0;
      end
      if (stall_left != 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left = gap_length();
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.status       = m_axis_tuser_o[1:0];
      got.op_type      = m_axis_tuser_o[4:2];
      got.list_empty   = m_axis_tuser_o[5];
      got.entry_clock  = m_axis_tdata_o[0];
      got.entry_app_id = m_axis_tdata_o[32:1];
      got.when         = m_axis_tdata_o[88:33];
      got.last         = m_axis_tlast_o;
      board.check_result(got);
    end
  end

  initial begin : stimulus
    req_t  directed [$];
    date_t no_date;
    no_date = calendar(16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    idling    = 1'b0;
    sink_hold = 0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= OP_SET;
    rst_ni          <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty lists, extreme keys and times, every date rule, replace, miss,
    // bad partition, bad clock type and the unknown command
    directed.push_back(build_request(OP_LIST, 8'd1, 8'd0, 32'h0, 32'h0, no_date));
    directed.push_back(build_request(OP_LIST, 8'd1, 8'd1, 32'h0, 32'h0, no_date));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd0, 32'h0, 32'hFFFF_FFFF, no_date));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd1, 32'hFFFF_FFFF, 32'h0,
                                     calendar(16'd2105, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59)));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd1, 32'd5, 32'h0,
                                     calendar(16'd1970, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0)));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd1, 32'd6, 32'h0,
                                     calendar(16'd2000, 8'd2, 8'd29, 8'd12, 8'd30, 8'd30)));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd1, 32'd7, 32'h0,
                                     calendar(16'd2100, 8'd2, 8'd29, 8'd1, 8'd1, 8'd1)));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd1, 32'd8, 32'h0,
                                     calendar(16'd2024, 8'd2, 8'd30, 8'd1, 8'd1, 8'd1)));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd1, 32'd9, 32'h0,
                                     calendar(16'd1969, 8'd6, 8'd15, 8'd1, 8'd1, 8'd1)));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd1, 32'd9, 32'h0,
                                     calendar(16'd2106, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0)));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd1, 32'd9, 32'h0,
                                     calendar(16'd2020, 8'd13, 8'd1, 8'd0, 8'd0, 8'd0)));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd1, 32'd9, 32'h0,
                                     calendar(16'd2020, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0)));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd1, 32'd9, 32'h0,
                                     calendar(16'd2020, 8'd4, 8'd31, 8'd0, 8'd0, 8'd0)));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd1, 32'd9, 32'h0,
                                     calendar(16'd2020, 8'd5, 8'd5, 8'd24, 8'd0, 8'd0)));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd1, 32'd9, 32'h0,
                                     calendar(16'd2020, 8'd5, 8'd5, 8'd0, 8'd60, 8'd0)));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd1, 32'd9, 32'h0,
                                     calendar(16'd2020, 8'd5, 8'd5, 8'd0, 8'd0, 8'd60)));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd0, 32'h0, 32'd5, no_date));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd1, 32'd5, 32'h0,
                                     calendar(16'd2038, 8'd1, 8'd19, 8'd3, 8'd14, 8'd7)));
    directed.push_back(build_request(OP_LIST, 8'd1, 8'd0, 32'h0, 32'h0, no_date));
    directed.push_back(build_request(OP_LIST, 8'd1, 8'd1, 32'h0, 32'h0, no_date));
    directed.push_back(build_request(OP_CLEAR, 8'd1, 8'd0, 32'h0, 32'h0, no_date));
    directed.push_back(build_request(OP_CLEAR, 8'd1, 8'd0, 32'h0, 32'h0, no_date));
    directed.push_back(build_request(OP_CLEAR, 8'd1, 8'd1, 32'hFFFF_FFFF, 32'h0, no_date));
    directed.push_back(build_request(OP_SET, 8'd0, 8'd0, 32'd11, 32'd1, no_date));
    directed.push_back(build_request(OP_SET, 8'd1, 8'd2, 32'd12, 32'd1, no_date));
    directed.push_back(build_request(OP_CLEAR, 8'd1, 8'hFF, 32'd13, 32'h0, no_date));
    directed.push_back(build_request(OP_UNKNOWN, 8'd1, 8'd0, 32'd14, 32'h0, no_date));
    directed.push_back(build_request(OP_LIST, 8'd1, 8'd2, 32'h0, 32'h0, no_date));
    directed.push_back(build_request(OP_LIST, 8'hFE, 8'd0, 32'h0, 32'h0, no_date));
    foreach (directed[i]) send_request(directed[i]);
    drain_answers();

    // Widest window and top partition; set-heavy so the table fills up
    configure(8'hFF, 16'd0, 16'hFFFF);
    idling = 1'b1;
    random_phase(70, 60, 20);

    // Empty year window: no absolute set can pass
    configure(8'h00, 16'd2000, 16'd1999);
    random_phase(50, 40, 25);

    // Receiver holds off while requests keep coming, mostly lists
    configure(8'h5A, 16'd1900, 16'd2400);
    idling = 1'b0;
    sink_hold = HOLD_OFF;
    random_phase(40, 20, 15);

    configure(8'h01, 16'hFFFF, 16'hFFFF);
    idling = 1'b1;
    random_phase(40, 40, 30);

    configure(8'($urandom), 16'($urandom_range(1600, 2000)), 16'($urandom_range(2000, 2500)));
    random_phase(100, 45, 30);

    repeat (DRAIN) @(posedge clk_i);
    $display("covered %0d requests under six register settings: %0d results checked",
             board.requests, board.results);
    $display("%0d entries listed, %0d empty lists, %0d sets refused on a full table, %0d clear misses",
             board.listed, board.empty_lists, board.full_refusals, board.clear_misses);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
